[rtl/sorted_record_table_macros.svh]
// assertion macros shared by the checker of the sorted record table
`ifndef SORTED_RECORD_TABLE_MACROS_SVH
`define SORTED_RECORD_TABLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define SRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted record table check failed");

// next-cycle implication, checked out of reset
`define SRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted record table check failed");

`endif

[rtl/srt_pkg.sv]
// package: codes, constants, types and key helper for the sorted record table
package srt_pkg;

  localparam int SRT_CAPACITY   = 16;
  localparam int SRT_NAME_CHARS = 8;
  localparam int KEY_W          = 64;
  localparam int POS_W          = 8;

  // operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } srt_state_t;

  // request broadcast to every cell of the chain
  typedef struct packed {
    logic              add_en;
    logic [KEY_W-1:0]  name_k;
    logic [KEY_W-1:0]  surname_k;
    logic [POS_W-1:0]  rd_idx;
  } srt_req_t;

  // keep the top NAME_CHARS bytes up to the first zero byte
  function automatic logic [KEY_W-1:0] srt_canon(input logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] res;
    logic             live;
    int               i;
    res  = '0;
    live = 1'b1;
    for (i = 0; i < 8; i++) begin
      if (key[KEY_W-1-8*i -: 8] == 8'd0) live = 1'b0;
      if (live && (i < SRT_NAME_CHARS)) res[KEY_W-1-8*i -: 8] = key[KEY_W-1-8*i -: 8];
    end
    return res;
  endfunction

endpackage

[rtl/srt_ifs.sv]
// valid/ready channel interfaces for request and result words

interface srt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [63:0] name_key;
  logic [63:0] surname_key;
  logic [7:0]  position;

  modport source (output valid, op, name_key, surname_key, position, input ready);
  modport sink   (input valid, op, name_key, surname_key, position, output ready);
endinterface

interface srt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] out_name;
  logic [63:0] out_surname;

  modport source (output valid, status, out_name, out_surname, input ready);
  modport sink   (input valid, status, out_name, out_surname, output ready);
endinterface

[rtl/sorted_record_table.sv]
// top level: sorted record table built as a shifting chain of cells
//
// Usage: request words arrive on in_ch (op, name_key, surname_key, position),
// one result word per request leaves on out_ch (status, out_name, out_surname).
// Both channels move a word when valid and ready are high at a clock edge.
// An add inserts the record after all stored records with an equal or smaller
// name; every cell compares and shifts at once.
// A read returns the record at the given 1-based position (0 reads as 1); a
// search reports whether the exact name and surname pair is stored.
// The control alternates between its idle state, which captures a request,
// and its execute state, which updates the chain; a new request is taken
// only in the idle state, so one request is handled at a time.
// A result waiting in the output register does not block the next request;
// if the receiver stalls, the following request is held in its execute cycle
// until the output register frees.
// Reset (rst_n low, synchronous) empties the table, clears the output valid
// and returns the control to idle; record storage itself is not cleared, the fill count marks live cells.
module sorted_record_table #(
  parameter int CAPACITY = srt_pkg::SRT_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  srt_in_if.sink    in_ch,
  srt_out_if.source out_ch
);
  import srt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY+1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  srt_state_t       state_r, state_nxt;
  logic [1:0]       op_r;
  logic [KEY_W-1:0] name_r;
  logic [KEY_W-1:0] surname_r;
  logic [POS_W-1:0] pos_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [KEY_W-1:0] oname_r, oname_nxt;
  logic [KEY_W-1:0] osurname_r, osurname_nxt;

  logic             stall;
  logic             accept;
  logic             exec_go;
  logic             not_full;
  logic [POS_W-1:0] pos_eff;
  logic             rd_ok;
  srt_req_t         req;

  logic [CAPACITY-1:0] ins_v, hit_v, sel_v;
  logic [KEY_W-1:0]    cname [CAPACITY];
  logic [KEY_W-1:0]    csurname [CAPACITY];
  logic [KEY_W-1:0]    rd_name, rd_surname;

  assign stall    = out_valid_r && !out_ch.ready;
  assign accept   = in_ch.valid && in_ch.ready;
  assign exec_go  = (state_r == S_EXEC) && !stall;
  assign not_full = count_r < CAP_C;
  assign pos_eff  = (pos_r == '0) ? POS_W'(1) : pos_r;
  assign rd_ok    = {1'b0, pos_eff} <= (POS_W+1)'(count_r);

  // request to the chain
  always_comb begin
    req.add_en    = exec_go && (op_r == OP_ADD) && not_full;
    req.name_k    = name_r;
    req.surname_k = surname_r;
    req.rd_idx    = pos_eff - POS_W'(1);
  end

  // chain of cells, each fed by its left neighbour
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    srt_cell #(.CAPACITY(CAPACITY), .CELL_IDX(g)) u_cell (
      .clk          (clk),
      .req          (req),
      .count        (count_r),
      .ins_prev     ((g == 0) ? 1'b0 : ins_v[(g == 0) ? 0 : g-1]),
      .prev_name    (cname[(g == 0) ? 0 : g-1]),
      .prev_surname (csurname[(g == 0) ? 0 : g-1]),
      .ins          (ins_v[g]),
      .name         (cname[g]),
      .surname      (csurname[g]),
      .hit          (hit_v[g]),
      .sel          (sel_v[g])
    );
  end

  // read select: or of the one selected cell
  always_comb begin
    rd_name    = '0;
    rd_surname = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (sel_v[i]) begin
        rd_name    = rd_name | cname[i];
        rd_surname = rd_surname | csurname[i];
      end
    end
  end

  // state register and request capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_ch.op;
      name_r    <= srt_canon(in_ch.name_key);
      surname_r <= srt_canon(in_ch.surname_key);
      pos_r     <= in_ch.position;
    end
    status_r   <= status_nxt;
    oname_r    <= oname_nxt;
    osurname_r <= osurname_nxt;
  end

  // next state, count and result word
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    oname_nxt     = oname_r;
    osurname_nxt  = osurname_r;
    in_ch.ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (!stall) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          status_nxt    = ST_NOT_FOUND;
          oname_nxt     = '0;
          osurname_nxt  = '0;
          case (op_r)
            OP_ADD: begin
              if (not_full) begin
                status_nxt = ST_OK;
                count_nxt  = count_r + CNT_W'(1);
              end else begin
                status_nxt = ST_FULL;
              end
            end
            OP_READ: begin
              if (rd_ok) begin
                status_nxt   = ST_OK;
                oname_nxt    = rd_name;
                osurname_nxt = rd_surname;
              end
            end
            OP_SEARCH: begin
              if (|hit_v) status_nxt = ST_OK;
            end
            default: status_nxt = ST_NOT_FOUND;
          endcase
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.out_name    = oname_r;
  assign out_ch.out_surname = osurname_r;

endmodule

[rtl/srt_cell.sv]
// one cell of the sorted chain: holds a record, shifts right on insert
module srt_cell #(
  parameter int CAPACITY = srt_pkg::SRT_CAPACITY,
  parameter int CELL_IDX = 0
) (
  input  logic                                clk,
  input  srt_pkg::srt_req_t                   req,
  input  logic [$clog2(CAPACITY+1)-1:0]       count,
  input  logic                                ins_prev,
  input  logic [srt_pkg::KEY_W-1:0]           prev_name,
  input  logic [srt_pkg::KEY_W-1:0]           prev_surname,
  output logic                                ins,
  output logic [srt_pkg::KEY_W-1:0]           name,
  output logic [srt_pkg::KEY_W-1:0]           surname,
  output logic                                hit,
  output logic                                sel
);
  import srt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY+1);
  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(CELL_IDX);
  localparam logic [POS_W-1:0] IDX_P = POS_W'(CELL_IDX);

  logic [KEY_W-1:0] name_r;
  logic [KEY_W-1:0] surname_r;
  logic             occ;

  // occupancy from the fill count
  assign occ = IDX_C < count;

  // at or after the insert point: empty, or holds a strictly greater name
  assign ins = !occ || (name_r > req.name_k);

  // exact record match and read select
  assign hit = occ && (name_r == req.name_k) && (surname_r == req.surname_k);
  assign sel = (req.rd_idx == IDX_P);

  assign name    = name_r;
  assign surname = surname_r;

  // take the new record at the insert point, the neighbour's word after it
  always_ff @(posedge clk) begin
    if (req.add_en && ins) begin
      name_r    <= ins_prev ? prev_name    : req.name_k;
      surname_r <= ins_prev ? prev_surname : req.surname_k;
    end
  end

endmodule

[rtl/srt_checker.sv]
// port-level checker for the sorted record table, bound to the top level
`include "sorted_record_table_macros.svh"

module srt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [63:0] out_name,
  input logic [63:0] out_surname
);
  import srt_pkg::*;

  // one request in flight: no new word right after a taken one
  `SRT_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // only defined status codes are shown
  `SRT_ASSERT_NOW(a_status_code, out_valid,
    status == ST_OK || status == ST_NOT_FOUND || status == ST_FULL)

  // a failed or full result carries no record
  `SRT_ASSERT_NOW(a_fail_no_data, out_valid && status != ST_OK,
    out_name == 64'd0 && out_surname == 64'd0)

  // a result follows a taken request when the output is free
  `SRT_ASSERT_NEXT(a_result_follows, in_valid && in_ready && !out_valid,
    ##1 out_valid)

  // a stalled result word stays put until the receiver takes it
  `SRT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(status) && $stable(out_name) && $stable(out_surname))

endmodule

bind sorted_record_table srt_checker u_srt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .out_name    (out_ch.out_name),
  .out_surname (out_ch.out_surname)
);
